>>> design/sas_pkg.sv
// Shared types and codes for the sorted adjacency store.
`timescale 1ns / 1ps

package sas_pkg;

	// Request codes; the unused code behaves as a lookup.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// One stored edge: destination key and its weight.
	typedef struct packed {
		logic [7:0]         dest;
		logic signed [31:0] weight;
	} edge_entry_t;

endpackage

>>> design/sorted_adjacency_store.sv
// Each request reads its list length, compares s entries in a linear search (at most the degree),
// moves m entries and, for an insert that adds an edge, writes the new one; an index error goes
// straight to the result. One word is in work at a time; the next is taken once the result
// is in the output register. The edge memory, read and written at most once per cycle each, paces the work.
// After reset the length table is cleared, one node per cycle, over all NUM_NODES nodes;
// in_stall stays high during that pass. Configuration writes are taken at any time.
`timescale 1ns / 1ps

module sorted_adjacency_store import sas_pkg::*; #(
	parameter int NUM_NODES  = 256,
	parameter int MAX_DEGREE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration
	input  logic               cfg_wen,
	input  logic [8:0]         cfg_wdata,
	// Request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [7:0]         src_node,
	input  logic [7:0]         dest_node,
	input  logic signed [31:0] edge_weight,
	// Result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               found,
	output logic signed [31:0] weight_out,
	output logic [4:0]         degree
);

	localparam int NODE_W = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
	localparam int DEPTH  = NUM_NODES * MAX_DEGREE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W  = $clog2(MAX_DEGREE + 1);
	localparam int CMP_W  = ($clog2(NUM_NODES + 1) > 9) ? $clog2(NUM_NODES + 1) : 9;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_LEN    = 3'd2;
	localparam logic [2:0] S_SEARCH = 3'd3;
	localparam logic [2:0] S_ACT    = 3'd4;
	localparam logic [2:0] S_SHIFT  = 3'd5;
	localparam logic [2:0] S_PLACE  = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0]         state_q;
	logic [NODE_W-1:0]  clr_idx_q;
	logic [8:0]         node_count_q;

	// Request held for the duration of its work.
	logic [1:0]         req_q;
	logic [NODE_W-1:0]  src_q;
	logic [7:0]         dest_q;
	logic signed [31:0] wgt_q;
	logic [ADDR_W-1:0]  base_q;
	logic               err_q;

	// Search and shift bookkeeping.
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   pos_q;
	logic               hit_q;
	logic signed [31:0] wgt_found_q;
	logic [LEN_W-1:0]   cmp_idx_q;
	logic [LEN_W-1:0]   rd_idx_q;
	logic [LEN_W-1:0]   mv_left_q;
	logic               shift_up_q;

	// Result being built, and the output register.
	logic [1:0]         res_status_q;
	logic               res_found_q;
	logic signed [31:0] res_wout_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic signed [31:0] weight_out_q;
	logic [4:0]         degree_q;

	// Length table.
	logic [LEN_W-1:0]   len_mem [NUM_NODES];
	logic [LEN_W-1:0]   len_rd_q;
	logic               len_we;
	logic [NODE_W-1:0]  len_waddr;
	logic [LEN_W-1:0]   len_wdata;

	// Edge memory port signals.
	logic               edge_we;
	logic [ADDR_W-1:0]  edge_waddr;
	edge_entry_t        edge_wdata;
	logic               edge_re;
	logic [ADDR_W-1:0]  edge_raddr;
	edge_entry_t        edge_rd;

	// Accept and range check.
	logic               in_accept;
	logic               out_pop;
	logic [CMP_W-1:0]   limit;
	logic               range_err;
	logic [NODE_W-1:0]  src_idx_in;
	logic [LEN_W-1:0]   shift_wr_idx;
	logic [LEN_W-1:0]   shift_rd_next;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_pop   = out_valid_q && !out_stall;

	assign limit = (CMP_W'(node_count_q) < CMP_W'(NUM_NODES)) ?
		CMP_W'(node_count_q) : CMP_W'(NUM_NODES);
	assign range_err  = (CMP_W'(src_node) >= limit) || (CMP_W'(dest_node) >= limit);
	assign src_idx_in = NODE_W'(src_node);

	assign shift_wr_idx  = shift_up_q ? rd_idx_q + LEN_W'(1) : rd_idx_q - LEN_W'(1);
	assign shift_rd_next = shift_up_q ? rd_idx_q - LEN_W'(1) : rd_idx_q + LEN_W'(1);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_wen) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Length table write port: the clearing pass, then the new length of each request that passes the range check.
	always_comb begin
		len_we    = 1'b0;
		len_waddr = src_q;
		len_wdata = len_q;
		if (state_q == S_CLEAR) begin
			len_we    = 1'b1;
			len_waddr = clr_idx_q;
			len_wdata = '0;
		end else if (state_q == S_FIN && !err_q) begin
			len_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		if (in_accept) begin
			len_rd_q <= len_mem[src_idx_in];
		end
	end

	// Edge memory accesses for the search, the shift and the final write.
	always_comb begin
		edge_re    = 1'b0;
		edge_raddr = base_q;
		edge_we    = 1'b0;
		edge_waddr = base_q + ADDR_W'(pos_q);
		edge_wdata = '{dest: dest_q, weight: wgt_q};
		case (state_q)
			S_LEN: begin
				edge_re = (len_rd_q != '0);
			end
			S_SEARCH: begin
				if (edge_rd.dest < dest_q && cmp_idx_q + LEN_W'(1) != len_q) begin
					edge_re    = 1'b1;
					edge_raddr = base_q + ADDR_W'(cmp_idx_q + LEN_W'(1));
				end
			end
			S_ACT: begin
				if (req_q == REQ_INSERT && hit_q) begin
					edge_we = 1'b1;
				end else if (req_q == REQ_INSERT && len_q != LEN_W'(MAX_DEGREE)
						&& len_q != pos_q) begin
					edge_re    = 1'b1;
					edge_raddr = base_q + ADDR_W'(len_q - LEN_W'(1));
				end else if (req_q == REQ_REMOVE && hit_q && pos_q + LEN_W'(1) != len_q) begin
					edge_re    = 1'b1;
					edge_raddr = base_q + ADDR_W'(pos_q + LEN_W'(1));
				end
			end
			S_SHIFT: begin
				edge_we    = 1'b1;
				edge_waddr = base_q + ADDR_W'(shift_wr_idx);
				edge_wdata = edge_rd;
				if (mv_left_q != '0) begin
					edge_re    = 1'b1;
					edge_raddr = base_q + ADDR_W'(shift_rd_next);
				end
			end
			S_PLACE: begin
				edge_we = 1'b1;
			end
			default: begin
				edge_re = 1'b0;
			end
		endcase
	end

	sas_edge_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.re    (edge_re),
		.raddr (edge_raddr),
		.rdata (edge_rd)
	);

	// Request registers; payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q  <= req_type;
			src_q  <= src_idx_in;
			dest_q <= dest_node;
			wgt_q  <= edge_weight;
			base_q <= ADDR_W'(src_idx_in) * ADDR_W'(MAX_DEGREE);
		end
	end

	// Sequencer: clearing pass after reset, then per request length read, linear search, move of entries, result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + NODE_W'(1);
					if (clr_idx_q == NODE_W'(NUM_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						if (range_err) begin
							err_q        <= 1'b1;
							res_status_q <= ST_RANGE;
							res_found_q  <= 1'b0;
							res_wout_q   <= '0;
							len_q        <= '0;
							state_q      <= S_FIN;
						end else begin
							err_q   <= 1'b0;
							state_q <= S_LEN;
						end
					end
				end
				S_LEN: begin
					len_q     <= len_rd_q;
					cmp_idx_q <= '0;
					if (len_rd_q == '0) begin
						pos_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= S_ACT;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (edge_rd.dest >= dest_q) begin
						pos_q       <= cmp_idx_q;
						hit_q       <= (edge_rd.dest == dest_q);
						wgt_found_q <= edge_rd.weight;
						state_q     <= S_ACT;
					end else if (cmp_idx_q + LEN_W'(1) == len_q) begin
						pos_q   <= len_q;
						hit_q   <= 1'b0;
						state_q <= S_ACT;
					end else begin
						cmp_idx_q <= cmp_idx_q + LEN_W'(1);
					end
				end
				S_ACT: begin
					res_status_q <= ST_OK;
					res_found_q  <= hit_q;
					res_wout_q   <= '0;
					state_q      <= S_FIN;
					if (req_q == REQ_INSERT) begin
						if (!hit_q) begin
							if (len_q == LEN_W'(MAX_DEGREE)) begin
								res_status_q <= ST_FULL;
							end else if (len_q == pos_q) begin
								state_q <= S_PLACE;
							end else begin
								rd_idx_q   <= len_q - LEN_W'(1);
								mv_left_q  <= len_q - pos_q - LEN_W'(1);
								shift_up_q <= 1'b1;
								state_q    <= S_SHIFT;
							end
						end
					end else if (req_q == REQ_REMOVE) begin
						if (hit_q) begin
							len_q <= len_q - LEN_W'(1);
							if (pos_q + LEN_W'(1) != len_q) begin
								rd_idx_q   <= pos_q + LEN_W'(1);
								mv_left_q  <= len_q - pos_q - LEN_W'(2);
								shift_up_q <= 1'b0;
								state_q    <= S_SHIFT;
							end
						end
					end else begin
						res_wout_q <= hit_q ? wgt_found_q : '0;
					end
				end
				S_SHIFT: begin
					if (mv_left_q != '0) begin
						rd_idx_q  <= shift_rd_next;
						mv_left_q <= mv_left_q - LEN_W'(1);
					end else begin
						state_q <= shift_up_q ? S_PLACE : S_FIN;
					end
				end
				S_PLACE: begin
					len_q   <= len_q + LEN_W'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
			status_q     <= res_status_q;
			found_q      <= res_found_q;
			weight_out_q <= res_wout_q;
			degree_q     <= 5'(len_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign found      = found_q;
	assign weight_out = weight_out_q;
	assign degree     = degree_q;

endmodule

>>> design/sas_edge_ram.sv
// Edge entry memory with one write port and one registered read port.
`timescale 1ns / 1ps

module sas_edge_ram import sas_pkg::*; #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  edge_entry_t       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output edge_entry_t       rdata
);

	edge_entry_t mem [DEPTH];
	edge_entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port: data appears in the cycle after the read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the sorted adjacency store: queued request driver and result monitor.
`timescale 1ns / 1ps

module testbench;
	import sas_pkg::*;

	localparam int NODES = 256;
	localparam int DEGREE_CAP = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 100;
	// The fourth request code is unused and acts as a lookup.
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct {
		logic [1:0]         kind;
		logic [7:0]         src;
		logic [7:0]         dst;
		logic signed [31:0] w;
	} edge_req_t;

	typedef struct {
		logic [1:0]         st;
		logic               hit;
		logic signed [31:0] w;
		logic [4:0]         deg;
	} edge_rsp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic [8:0]         cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type = '0;
	logic [7:0]         src_node = '0;
	logic [7:0]         dest_node = '0;
	logic signed [31:0] edge_weight = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic               found;
	logic signed [31:0] weight_out;
	logic [4:0]         degree;

	// Shadow copy of the edge lists and the node_count register.
	int                 nodes_in_use = 0;
	int                 edge_count [NODES];
	logic [7:0]         nbr_dest [NODES][DEGREE_CAP];
	logic signed [31:0] nbr_weight [NODES][DEGREE_CAP];

	edge_req_t pending_words [$];
	edge_rsp_t awaited_results [$];
	edge_req_t on_wire;
	edge_rsp_t oldest;

	bit quiet = 1'b0;
	int failures = 0;
	int cycles = 0;
	int words_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int range_seen = 0;
	int full_seen = 0;
	int settings_used = 0;

	sorted_adjacency_store dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.src_node   (src_node),
		.dest_node  (dest_node),
		.edge_weight(edge_weight),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.found      (found),
		.weight_out (weight_out),
		.degree     (degree)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one request to the shadow lists and return the result it should give.
	function automatic edge_rsp_t apply_edge_request(edge_req_t r);
		int lim;
		int len;
		int pos;
		int k;
		bit hit;
		edge_rsp_t res;
		lim = nodes_in_use < NODES ? nodes_in_use : NODES;
		res.st = ST_OK;
		res.hit = 1'b0;
		res.w = '0;
		res.deg = '0;
		if (r.src >= lim || r.dst >= lim) begin
			res.st = ST_RANGE;
			return res;
		end
		len = edge_count[r.src];
		pos = 0;
		while (pos < len && nbr_dest[r.src][pos] < r.dst)
			pos++;
		hit = pos < len && nbr_dest[r.src][pos] == r.dst;
		res.hit = hit;
		case (r.kind)
			REQ_INSERT: begin
				if (hit) begin
					nbr_weight[r.src][pos] = r.w;
				end else if (len >= DEGREE_CAP) begin
					res.st = ST_FULL;
				end else begin
					for (k = len; k > pos; k--) begin
						nbr_dest[r.src][k] = nbr_dest[r.src][k - 1];
						nbr_weight[r.src][k] = nbr_weight[r.src][k - 1];
					end
					nbr_dest[r.src][pos] = r.dst;
					nbr_weight[r.src][pos] = r.w;
					len++;
				end
			end
			REQ_REMOVE: begin
				if (hit) begin
					for (k = pos; k + 1 < len; k++) begin
						nbr_dest[r.src][k] = nbr_dest[r.src][k + 1];
						nbr_weight[r.src][k] = nbr_weight[r.src][k + 1];
					end
					len--;
				end
			end
			default: begin
				if (hit)
					res.w = nbr_weight[r.src][pos];
			end
		endcase
		edge_count[r.src] = len;
		res.deg = 5'(len);
		return res;
	endfunction

	// Random request aimed at a few busy sources so that lists grow, fill and shrink.
	function automatic edge_req_t random_request(int span);
		int roll;
		int hot;
		edge_req_t r;
		hot = span > NODES ? NODES : span;
		if (hot < 1)
			hot = 1;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			r.kind = REQ_INSERT;
		else if (roll < 70)
			r.kind = REQ_LOOKUP;
		else if (roll < 93)
			r.kind = REQ_REMOVE;
		else
			r.kind = REQ_SPARE;
		if ($urandom_range(0, 99) < 85) begin
			r.src = 8'(($urandom_range(0, 3) * 67) % hot);
			r.dst = 8'($urandom_range(0, (hot < 24 ? hot : 24) - 1));
		end else begin
			r.src = 8'($urandom_range(0, 255));
			r.dst = 8'($urandom_range(0, 255));
		end
		roll = $urandom_range(0, 7);
		if (roll == 0)
			r.w = 32'sh8000_0000;
		else if (roll == 1)
			r.w = 32'sh7fff_ffff;
		else
			r.w = $urandom;
		return r;
	endfunction

	task automatic queue_request(logic [1:0] kind, int src, int dst, logic signed [31:0] w);
		edge_req_t r;
		r.kind = kind;
		r.src = 8'(src);
		r.dst = 8'(dst);
		r.w = w;
		pending_words.push_back(r);
	endtask

	// Hold until every queued word has gone out and its result has come back.
	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write node_count while the block is idle and mirror it in the shadow copy.
	task automatic write_node_count(int value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= 9'(value);
		@(posedge clk);
		cfg_wen <= 1'b0;
		nodes_in_use = value;
		settings_used++;
		@(negedge clk);
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// Driver: predict each accepted word, then present the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				awaited_results.push_back(apply_edge_request(on_wire));
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
					on_wire = pending_words.pop_front();
					req_type <= on_wire.kind;
					src_node <= on_wire.src;
					dest_node <= on_wire.dst;
					edge_weight <= on_wire.w;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result word with no request waiting for it");
					failures++;
				end else begin
					oldest = awaited_results.pop_front();
					compare_field("status", 32'(oldest.st), 32'(status));
					compare_field("found", 32'(oldest.hit), 32'(found));
					compare_field("weight_out", oldest.w, weight_out);
					compare_field("degree", 32'(oldest.deg), 32'(degree));
					results_seen++;
					if (oldest.hit)
						hits_seen++;
					if (oldest.st == ST_RANGE)
						range_seen++;
					if (oldest.st == ST_FULL)
						full_seen++;
				end
			end
			out_stall <= !quiet && $urandom_range(0, 99) < 10;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sorted_adjacency_store test failed");
			$finish;
		end
	end

	// Stimulus: reset, directed cases, then random phases under several node counts.
	initial begin
		int plan [6];
		int i;
		int p;
		plan = '{256, 20, 1, 256, 17, 0};
		plan[5] = $urandom_range(0, 256);
		for (i = 0; i < NODES; i++)
			edge_count[i] = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With node_count still at its reset value every index is out of range.
		queue_request(REQ_INSERT, 0, 0, 32'sd5);
		wait_drained();

		// Extremes of the node indices and of the weight, then update, and both removes.
		write_node_count(256);
		queue_request(REQ_INSERT, 0, 255, 32'sh8000_0000);
		queue_request(REQ_INSERT, 255, 0, 32'sh7fff_ffff);
		queue_request(REQ_LOOKUP, 0, 255, 32'sd0);
		queue_request(REQ_SPARE, 255, 0, 32'sd0);
		queue_request(REQ_INSERT, 0, 255, -32'sd1);
		queue_request(REQ_REMOVE, 0, 100, 32'sd0);
		queue_request(REQ_REMOVE, 0, 255, 32'sd0);
		// Fill one list front first, so that every insert after the first shifts the whole list.
		for (i = 15; i >= 0; i--)
			queue_request(REQ_INSERT, 7, 2 * i, 32'(i * 1000 - 7000));
		queue_request(REQ_INSERT, 7, 31, 32'sd1);
		queue_request(REQ_INSERT, 7, 14, 32'sh5555_aaaa);
		queue_request(REQ_REMOVE, 7, 0, 32'sd0);
		queue_request(REQ_LOOKUP, 7, 30, 32'sd0);
		wait_drained();

		// A small node count puts the range check on the source and on the destination.
		write_node_count(2);
		queue_request(REQ_INSERT, 1, 1, 32'sd9);
		queue_request(REQ_INSERT, 2, 0, 32'sd9);
		queue_request(REQ_LOOKUP, 0, 2, 32'sd0);
		wait_drained();

		// Random phases; the sender drains fully between them, one runs with no idling.
		for (p = 0; p < 6; p++) begin
			write_node_count(plan[p]);
			quiet = (p == 3);
			for (i = 0; i < RANDOM_PER_PHASE; i++)
				pending_words.push_back(random_request(plan[p]));
			wait_drained();
			quiet = 1'b0;
		end

		repeat (40) @(negedge clk);
		$display("Ran %0d requests under %0d node_count settings: %0d edges found,",
			words_sent, settings_used, hits_seen);
		$display("%0d index errors and %0d full-list rejects among %0d results.",
			range_seen, full_seen, results_seen);
		if (failures == 0 && awaited_results.size() == 0) begin
			$display("sorted_adjacency_store test passed");
		end else begin
			if (awaited_results.size() != 0)
				$error("%0d results never arrived", awaited_results.size());
			$display("sorted_adjacency_store test failed");
		end
		$finish;
	end

endmodule
